// ===== sv/psas_pkg.sv =====
// Shared types and constants of the per-sensor average sorter.
// No dependencies; used by the controller, datapath and top level.
package psas_pkg;

  // Field widths fixed by the item format
  localparam int unsigned OP_W   = 2;
  localparam int unsigned ID_W   = 7;
  localparam int unsigned TEMP_W = 11;
  localparam int unsigned KEY_W  = TEMP_W + ID_W;

  // Opcodes
  localparam logic [OP_W-1:0] OP_ADD  = 2'd0;
  localparam logic [OP_W-1:0] OP_EOP  = 2'd1;
  localparam logic [OP_W-1:0] OP_READ = 2'd2;

  // Window of averages kept in average order (tenths)
  localparam logic signed [TEMP_W-1:0] AVG_LOW  = -11'sd500;
  localparam logic signed [TEMP_W-1:0] AVG_HIGH = 11'sd500;

  // Controller to datapath commands
  typedef struct packed {
    logic load_in;    // capture input item fields
    logic sc_rd_id;   // read sum/count store at reading id
    logic sc_rd_idx;  // read sum/count store at sweep index
    logic sc_wr;      // write updated sum/count at reading id
    logic idx_clr;
    logic idx_inc;
    logic div_start;
    logic av_wr;      // write average store at sweep index
    logic av_rd;      // read average store at sweep index (scan)
    logic scan_clr;
    logic emit;       // load output register
    logic ready_set;
    logic ready_clr;
    logic rewind;
  } psas_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic id_ok;
    logic cnt_full;
    logic idx_last;
    logic div_done;
    logic out_busy;
    logic avg_ready;
  } psas_sts_t;

endpackage

// ===== sv/psas_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module psas_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/psas_ctrl.sv =====
// Controller state machine of the per-sensor average sorter.
// Depends on psas_pkg; drives psas_dpath through command/status structs.
module psas_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          opcode_i,
  input  psas_pkg::psas_sts_t sts_i,
  output psas_pkg::psas_cmd_t cmd_o
);
  import psas_pkg::*;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_ACC_RD  = 4'd1;
  localparam logic [3:0] S_ACC_WR  = 4'd2;
  localparam logic [3:0] S_EOP_RD  = 4'd3;
  localparam logic [3:0] S_EOP_LD  = 4'd4;
  localparam logic [3:0] S_EOP_DIV = 4'd5;
  localparam logic [3:0] S_EOP_WR  = 4'd6;
  localparam logic [3:0] S_SCAN    = 4'd7;
  localparam logic [3:0] S_SCAN_END = 4'd8;
  localparam logic [3:0] S_EMIT    = 4'd9;

  logic [3:0] state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          case (opcode_i)
            OP_ADD: begin
              cmd_o.ready_clr = 1'b1;
              state_d = S_ACC_RD;
            end
            OP_EOP: begin
              cmd_o.idx_clr = 1'b1;
              state_d = S_EOP_RD;
            end
            OP_READ: begin
              cmd_o.idx_clr  = 1'b1;
              cmd_o.scan_clr = 1'b1;
              state_d = sts_i.avg_ready ? S_SCAN : S_EMIT;
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_ACC_RD: begin
        cmd_o.sc_rd_id = 1'b1;
        state_d = sts_i.id_ok ? S_ACC_WR : S_IDLE;
      end
      S_ACC_WR: begin
        cmd_o.sc_wr = !sts_i.cnt_full;
        state_d = S_IDLE;
      end
      S_EOP_RD: begin
        cmd_o.sc_rd_idx = 1'b1;
        state_d = S_EOP_LD;
      end
      S_EOP_LD: begin
        cmd_o.div_start = 1'b1;
        state_d = S_EOP_DIV;
      end
      S_EOP_DIV: begin
        if (sts_i.div_done) begin
          state_d = S_EOP_WR;
        end
      end
      S_EOP_WR: begin
        cmd_o.av_wr = 1'b1;
        if (sts_i.idx_last) begin
          cmd_o.ready_set = 1'b1;
          cmd_o.rewind    = 1'b1;
          state_d = S_IDLE;
        end else begin
          cmd_o.idx_inc = 1'b1;
          state_d = S_EOP_RD;
        end
      end
      S_SCAN: begin
        cmd_o.av_rd = 1'b1;
        if (sts_i.idx_last) begin
          state_d = S_SCAN_END;
        end else begin
          cmd_o.idx_inc = 1'b1;
        end
      end
      S_SCAN_END: state_d = S_EMIT;
      S_EMIT: begin
        if (!sts_i.out_busy) begin
          cmd_o.emit = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Output register is never overwritten while its item waits
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> !sts_i.out_busy) else $error("emit while output busy");

  // A store update always follows its read
  a_wr_after_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.sc_wr |-> $past(cmd_o.sc_rd_id)) else $error("write without read");

  // Average written only with a finished quotient
  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.av_wr |-> sts_i.div_done) else $error("average written mid-division");

endmodule

// ===== sv/psas_dpath.sv =====
// Datapath: sum/count and average stores, serial divider, ordered scan, output register.
// Depends on psas_pkg and psas_ram.
module psas_dpath #(
  parameter int unsigned NUM_SENSORS = 100,
  parameter int unsigned COUNT_BITS  = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  psas_pkg::psas_cmd_t                  cmd_i,
  output psas_pkg::psas_sts_t                  sts_o,
  input  logic [psas_pkg::ID_W-1:0]            sensor_id_i,
  input  logic signed [psas_pkg::TEMP_W-1:0]   temperature_tenths_i,
  input  logic                                 cfg_we_i,
  input  logic                                 cfg_sort_mode_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic                                 has_entry_o,
  output logic [psas_pkg::ID_W-1:0]            out_sensor_id_o,
  output logic signed [psas_pkg::TEMP_W-1:0]   average_tenths_o,
  output logic                                 last_entry_o
);
  import psas_pkg::*;

  localparam int unsigned IDX_W = $clog2(NUM_SENSORS);
  localparam int unsigned SUM_W = COUNT_BITS + TEMP_W;
  localparam int unsigned SC_W  = SUM_W + COUNT_BITS;
  localparam int unsigned NUM_W = SUM_W + 1;
  localparam int unsigned DEN_W = COUNT_BITS + 1;
  localparam int unsigned DC_W  = $clog2(NUM_W + 1);
  localparam int unsigned AV_W  = TEMP_W + 1;

  // Captured item fields
  logic [ID_W-1:0]          id_q;
  logic signed [TEMP_W-1:0] temp_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      id_q   <= sensor_id_i;
      temp_q <= temperature_tenths_i;
    end
  end

  logic id_ok;
  assign id_ok = ({1'b0, id_q} < (ID_W+1)'(NUM_SENSORS));

  // Sweep index
  logic [IDX_W-1:0] idx_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (cmd_i.idx_clr) begin
      idx_q <= '0;
    end else if (cmd_i.idx_inc) begin
      idx_q <= idx_q + 1'b1;
    end
  end

  // Sum/count store with per-entry valid bits (unwritten entries read as zero)
  logic [IDX_W-1:0] sc_raddr;
  logic [SC_W-1:0]  sc_rdata, sc_wdata;
  logic             sc_re;
  logic [NUM_SENSORS-1:0] vld_q;
  logic             vld_rd_q;

  assign sc_re    = cmd_i.sc_rd_id | cmd_i.sc_rd_idx;
  assign sc_raddr = cmd_i.sc_rd_idx ? idx_q : id_q[IDX_W-1:0];

  psas_ram #(.WIDTH(SC_W), .DEPTH(NUM_SENSORS)) u_sc_ram (
    .clk_i,
    .we_i    (cmd_i.sc_wr),
    .waddr_i (id_q[IDX_W-1:0]),
    .wdata_i (sc_wdata),
    .re_i    (sc_re),
    .raddr_i (sc_raddr),
    .rdata_o (sc_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      vld_rd_q <= 1'b0;
    end else begin
      if (sc_re) begin
        vld_rd_q <= vld_q[sc_raddr];
      end
      if (cmd_i.sc_wr) begin
        vld_q[id_q[IDX_W-1:0]] <= 1'b1;
      end
    end
  end

  logic signed [SUM_W-1:0] cur_sum;
  logic [COUNT_BITS-1:0]   cur_cnt;
  assign cur_sum = vld_rd_q ? $signed(sc_rdata[SC_W-1:COUNT_BITS]) : '0;
  assign cur_cnt = vld_rd_q ? sc_rdata[COUNT_BITS-1:0] : '0;
  assign sc_wdata = {cur_sum + SUM_W'(temp_q), cur_cnt + 1'b1};

  // Serial restoring divider: (2|sum| + count) / (2 count), one bit a cycle
  logic [NUM_W-1:0] num_q;
  logic [DEN_W-1:0] den_q, rem_q;
  logic [DC_W-1:0]  dcnt_q;
  logic             busy_q, neg_q, pres_q;
  logic [DEN_W:0]   shifted;
  logic             qbit;
  logic [SUM_W-1:0] mag;

  assign mag     = cur_sum[SUM_W-1] ? SUM_W'(-cur_sum) : SUM_W'(cur_sum);
  assign shifted = {rem_q, num_q[NUM_W-1]};
  assign qbit    = (shifted >= {1'b0, den_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      dcnt_q <= '0;
    end else if (cmd_i.div_start) begin
      busy_q <= 1'b1;
      dcnt_q <= DC_W'(NUM_W);
    end else if (busy_q) begin
      dcnt_q <= dcnt_q - 1'b1;
      if (dcnt_q == DC_W'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      num_q  <= {mag, 1'b0} + NUM_W'(cur_cnt);
      den_q  <= {cur_cnt, 1'b0};
      rem_q  <= '0;
      neg_q  <= cur_sum[SUM_W-1];
      pres_q <= (cur_cnt != '0);
    end else if (busy_q) begin
      rem_q <= qbit ? DEN_W'(shifted - {1'b0, den_q}) : shifted[DEN_W-1:0];
      num_q <= {num_q[NUM_W-2:0], qbit};
    end
  end

  logic signed [TEMP_W-1:0] quot;
  assign quot = neg_q ? -$signed(num_q[TEMP_W-1:0]) : $signed(num_q[TEMP_W-1:0]);

  // Average store: {has readings, rounded average}
  logic [AV_W-1:0] av_rdata, av_wdata;
  assign av_wdata = pres_q ? {1'b1, quot} : '0;

  psas_ram #(.WIDTH(AV_W), .DEPTH(NUM_SENSORS)) u_av_ram (
    .clk_i,
    .we_i    (cmd_i.av_wr),
    .waddr_i (idx_q),
    .wdata_i (av_wdata),
    .re_i    (cmd_i.av_rd),
    .raddr_i (idx_q),
    .rdata_o (av_rdata)
  );

  // Mode, ready flag and cursor
  logic             mode_q, ready_q, started_q;
  logic [KEY_W-1:0] cursor_q;

  // Scan accumulator
  logic             pend_q;
  logic [IDX_W-1:0] rd_idx_q;
  logic             found_q;
  logic [1:0]       ncand_q;
  logic [KEY_W-1:0] best_key_q;
  logic [IDX_W-1:0] best_idx_q;
  logic signed [TEMP_W-1:0] best_avg_q;

  logic signed [TEMP_W-1:0] e_avg;
  logic             e_elig, e_above;
  logic [KEY_W-1:0] e_key;

  assign e_avg  = $signed(av_rdata[TEMP_W-1:0]);
  assign e_elig = av_rdata[TEMP_W] &&
                  (!mode_q || (e_avg >= AVG_LOW && e_avg <= AVG_HIGH));
  assign e_key  = mode_q ? {~e_avg[TEMP_W-1], e_avg[TEMP_W-2:0], ID_W'(rd_idx_q)}
                         : KEY_W'(rd_idx_q);
  assign e_above = !started_q || (e_key > cursor_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q  <= 1'b0;
      found_q <= 1'b0;
      ncand_q <= '0;
    end else begin
      pend_q <= cmd_i.av_rd;
      if (cmd_i.scan_clr) begin
        found_q <= 1'b0;
        ncand_q <= '0;
      end else if (pend_q && e_elig && e_above) begin
        found_q <= 1'b1;
        if (ncand_q != 2'd2) begin
          ncand_q <= ncand_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.av_rd) begin
      rd_idx_q <= idx_q;
    end
    if (pend_q && e_elig && e_above && (!found_q || e_key < best_key_q)) begin
      best_key_q <= e_key;
      best_idx_q <= rd_idx_q;
      best_avg_q <= e_avg;
    end
  end

  logic hit;
  assign hit = ready_q && found_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= 1'b0;
      ready_q   <= 1'b0;
      started_q <= 1'b0;
      cursor_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        mode_q    <= cfg_sort_mode_i;
        started_q <= 1'b0;
      end else if (cmd_i.rewind) begin
        started_q <= 1'b0;
      end else if (cmd_i.emit && hit) begin
        started_q <= 1'b1;
        cursor_q  <= best_key_q;
      end
      if (cmd_i.ready_set) begin
        ready_q <= 1'b1;
      end else if (cmd_i.ready_clr) begin
        ready_q <= 1'b0;
      end
    end
  end

  // Output register
  logic out_valid_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      has_entry_o      <= hit;
      out_sensor_id_o  <= hit ? ID_W'(best_idx_q) : '0;
      average_tenths_o <= hit ? best_avg_q : '0;
      last_entry_o     <= hit && (ncand_q == 2'd1);
    end
  end

  assign out_valid_o = out_valid_q;

  // Status
  assign sts_o.id_ok     = id_ok;
  assign sts_o.cnt_full  = (cur_cnt == '1);
  assign sts_o.idx_last  = (idx_q == IDX_W'(NUM_SENSORS - 1));
  assign sts_o.div_done  = !busy_q;
  assign sts_o.out_busy  = out_valid_q && !out_ready_i;
  assign sts_o.avg_ready = ready_q;

endmodule

// ===== sv/per_sensor_average_sorter.sv =====
// Per-sensor average sorter: a reading item reads and writes back its sensor's sum/count entry;
// a read-next scans every average entry, then loads the output register (without a scan before
// averages are ready). End of packet averages each sensor in turn with the bit-serial divider.
// One item at a time; a read-next stalls while the previous result waits in the output register.
// Asynchronous active-low reset clears all sums, counts and flags at once through per-entry
// valid bits; no clearing pass. Depends on psas_pkg, psas_ctrl, psas_dpath.
module per_sensor_average_sorter #(
  parameter int unsigned NUM_SENSORS = 100,
  parameter int unsigned COUNT_BITS  = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic                                 cfg_sort_mode_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [psas_pkg::OP_W-1:0]            opcode_i,
  input  logic [psas_pkg::ID_W-1:0]            sensor_id_i,
  input  logic signed [psas_pkg::TEMP_W-1:0]   temperature_tenths_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic                                 has_entry_o,
  output logic [psas_pkg::ID_W-1:0]            out_sensor_id_o,
  output logic signed [psas_pkg::TEMP_W-1:0]   average_tenths_o,
  output logic                                 last_entry_o
);
  import psas_pkg::*;

  psas_cmd_t cmd;
  psas_sts_t sts;

  assign cfg_ready_o = 1'b1;

  psas_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .opcode_i,
    .sts_i (sts),
    .cmd_o (cmd)
  );

  psas_dpath #(.NUM_SENSORS(NUM_SENSORS), .COUNT_BITS(COUNT_BITS)) u_dpath (
    .clk_i,
    .rst_ni,
    .cmd_i            (cmd),
    .sts_o            (sts),
    .sensor_id_i,
    .temperature_tenths_i,
    .cfg_we_i         (cfg_valid_i),
    .cfg_sort_mode_i,
    .out_valid_o,
    .out_ready_i,
    .has_entry_o,
    .out_sensor_id_o,
    .average_tenths_o,
    .last_entry_o
  );

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for per_sensor_average_sorter: readings, end of packet and
// read-next items against an in-bench model of sums, averages and output order.
// Depends on psas_pkg and the block's RTL only.
`timescale 1ns / 100ps

module tb;
  import psas_pkg::*;

  localparam int unsigned NUM_SENSORS = 100;
  localparam int unsigned COUNT_BITS  = 16;
  localparam int          COUNT_MAX   = (1 << COUNT_BITS) - 1;
  localparam int          EOP_CYCLES  = NUM_SENSORS * (COUNT_BITS + 16);
  localparam logic [OP_W-1:0] OP_NONE = 2'd3;  // unused opcode, ignored by the block

  typedef struct packed {
    logic                     has_entry;
    logic [ID_W-1:0]          sensor_id;
    logic signed [TEMP_W-1:0] average;
    logic                     last_entry;
  } sorted_entry_t;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     cfg_valid_i;
  logic                     cfg_ready_o;
  logic                     cfg_sort_mode_i;
  logic                     in_valid_i;
  logic                     in_ready_o;
  logic [OP_W-1:0]          opcode_i;
  logic [ID_W-1:0]          sensor_id_i;
  logic signed [TEMP_W-1:0] temperature_tenths_i;
  logic                     out_valid_o;
  logic                     out_ready_i;
  logic                     has_entry_o;
  logic [ID_W-1:0]          out_sensor_id_o;
  logic signed [TEMP_W-1:0] average_tenths_o;
  logic                     last_entry_o;

  per_sensor_average_sorter #(
    .NUM_SENSORS (NUM_SENSORS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_valid_i          (cfg_valid_i),
    .cfg_ready_o          (cfg_ready_o),
    .cfg_sort_mode_i      (cfg_sort_mode_i),
    .in_valid_i           (in_valid_i),
    .in_ready_o           (in_ready_o),
    .opcode_i             (opcode_i),
    .sensor_id_i          (sensor_id_i),
    .temperature_tenths_i (temperature_tenths_i),
    .out_valid_o          (out_valid_o),
    .out_ready_i          (out_ready_i),
    .has_entry_o          (has_entry_o),
    .out_sensor_id_o      (out_sensor_id_o),
    .average_tenths_o     (average_tenths_o),
    .last_entry_o         (last_entry_o)
  );

  // Model state
  longint        sum_m   [NUM_SENSORS];
  int            count_m [NUM_SENSORS];
  int            avg_m   [NUM_SENSORS];
  int            cursor_key;
  bit            cursor_started;
  bit            averages_ready;
  bit            sort_mode_m;
  sorted_entry_t entry_q[$];
  int            error_cnt;
  int            item_cnt;

  // Idling control
  bit steady_in;
  int burst_left;
  int hold_left;
  int run_left;
  bit rdy_state;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Run limit
  initial begin
    #40_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Model helpers
  function automatic bit in_order(int i);
    if (count_m[i] == 0) return 1'b0;
    if (sort_mode_m) return avg_m[i] >= int'(AVG_LOW) && avg_m[i] <= int'(AVG_HIGH);
    return 1'b1;
  endfunction

  function automatic int order_key(int i);
    if (sort_mode_m) return ((avg_m[i] + 1024) << 7) | i;
    return i;
  endfunction

  // Eligible sensor with the smallest key above the floor, NUM_SENSORS if none
  function automatic int next_sensor(bit have_floor, int floor_key);
    int best;
    int best_key;
    int k;
    best = NUM_SENSORS;
    best_key = 0;
    for (int i = 0; i < NUM_SENSORS; i++) begin
      if (!in_order(i)) continue;
      k = order_key(i);
      if (have_floor && k <= floor_key) continue;
      if (best == NUM_SENSORS || k < best_key) begin
        best = i;
        best_key = k;
      end
    end
    return best;
  endfunction

  function automatic int rounded_avg(longint sum, int cnt);
    longint mag;
    longint q;
    if (cnt == 0) return 0;
    mag = (sum < 0) ? -sum : sum;
    q = (2 * mag + cnt) / (2 * cnt);
    return (sum < 0) ? -int'(q) : int'(q);
  endfunction

  function automatic int eligible_count();
    int n;
    n = 0;
    for (int i = 0; i < NUM_SENSORS; i++) if (in_order(i)) n++;
    return n;
  endfunction

  // Update the model for one accepted item, queue the result it causes
  task automatic predict_sorter(logic [OP_W-1:0] op, logic [ID_W-1:0] id,
                                logic signed [TEMP_W-1:0] temp);
    sorted_entry_t e;
    int hit;
    e = '0;
    case (op)
      OP_ADD: begin
        if (id < NUM_SENSORS && count_m[id] < COUNT_MAX) begin
          sum_m[id] += longint'(temp);
          count_m[id]++;
        end
        averages_ready = 1'b0;
      end
      OP_EOP: begin
        for (int i = 0; i < NUM_SENSORS; i++) avg_m[i] = rounded_avg(sum_m[i], count_m[i]);
        averages_ready = 1'b1;
        cursor_key = 0;
        cursor_started = 1'b0;
      end
      OP_READ: begin
        if (averages_ready) begin
          hit = next_sensor(cursor_started, cursor_key);
          if (hit < NUM_SENSORS) begin
            cursor_key = order_key(hit) & 'h3FFFF;
            cursor_started = 1'b1;
            e.has_entry = 1'b1;
            e.sensor_id = hit[ID_W-1:0];
            e.average = avg_m[hit][TEMP_W-1:0];
            e.last_entry = (next_sensor(1'b1, cursor_key) >= NUM_SENSORS);
          end
        end
        entry_q.push_back(e);
      end
      default: ;
    endcase
  endtask

  // Send one item: bursts with random gaps unless steady
  task automatic send_item(logic [OP_W-1:0] op, logic [ID_W-1:0] id,
                           logic signed [TEMP_W-1:0] temp);
    @(negedge clk_i);
    if (!steady_in) begin
      if (burst_left == 0) begin
        in_valid_i = 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk_i);
        burst_left = $urandom_range(1, 12);
      end
      burst_left--;
    end
    in_valid_i = 1'b1;
    opcode_i = op;
    sensor_id_i = id;
    temperature_tenths_i = temp;
    do @(posedge clk_i); while (!in_ready_o);
    predict_sorter(op, id, temp);
    item_cnt++;
  endtask

  task automatic send_reading(int id, int temp);
    send_item(OP_ADD, id[ID_W-1:0], temp[TEMP_W-1:0]);
  endtask

  task automatic send_reads(int n);
    repeat (n) send_item(OP_READ, ID_W'($urandom), TEMP_W'($urandom));
  endtask

  // Drop valid, drain results, then allow for an end of packet still running
  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    wait (entry_q.size() == 0);
    repeat (EOP_CYCLES + 200) @(posedge clk_i);
  endtask

  task automatic write_sort_mode(logic m);
    wait_idle();
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_sort_mode_i = m;
    do @(posedge clk_i); while (!cfg_ready_o);
    sort_mode_m = m;
    cursor_key = 0;
    cursor_started = 1'b0;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // Result check
  always @(posedge clk_i) begin
    sorted_entry_t got;
    sorted_entry_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = {has_entry_o, out_sensor_id_o, average_tenths_o, last_entry_o};
      if (entry_q.size() == 0) begin
        $display("%0t: unexpected item, expected none, actual %p", $time, got);
        error_cnt++;
      end else begin
        want = entry_q.pop_front();
        if (got.has_entry !== want.has_entry) begin
          $display("%0t: has_entry expected %0d actual %0d", $time, want.has_entry,
                   got.has_entry);
          error_cnt++;
        end
        if (got.sensor_id !== want.sensor_id) begin
          $display("%0t: sensor_id expected %0d actual %0d", $time, want.sensor_id,
                   got.sensor_id);
          error_cnt++;
        end
        if (got.average !== want.average) begin
          $display("%0t: average expected %0d actual %0d", $time, want.average,
                   got.average);
          error_cnt++;
        end
        if (got.last_entry !== want.last_entry) begin
          $display("%0t: last_entry expected %0d actual %0d", $time, want.last_entry,
                   got.last_entry);
          error_cnt++;
        end
      end
    end
  end

  // Receiver: runs of ready and stalls, plus a requested long hold-off
  initial begin
    out_ready_i = 1'b0;
    run_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        out_ready_i = 1'b0;
        hold_left--;
      end else begin
        if (run_left == 0) begin
          rdy_state = ($urandom_range(0, 3) != 0);
          run_left = rdy_state ? $urandom_range(1, 20) : $urandom_range(1, 6);
        end
        out_ready_i = rdy_state;
        run_left--;
      end
    end
  end

  // Extremes, rounding, ignored items, both orders, exhaustion
  task automatic test_directed();
    send_reads(1);                      // read before any averages
    send_item(OP_NONE, '1, '1);         // unknown opcode
    send_reading(0, -1024);
    send_reading(99, 1023);
    send_reading(5, 5);
    send_reading(5, -10);               // -2.5 rounds to -3
    send_reading(7, 15);
    send_reading(7, 16);                // 15.5 rounds to 16
    send_reading(42, 0);
    send_reading(100, 300);             // id out of range
    send_reading(127, -300);
    send_item(OP_EOP, '0, '0);
    send_reads(eligible_count() + 2);   // runs past the end
    write_sort_mode(1'b1);
    send_reads(eligible_count() + 2);   // out-of-window averages skipped
    send_reading(7, 1);                 // reading after end of packet
    send_reads(1);
  endtask

  // Long receiver hold-off while reads keep coming
  task automatic test_backpressure();
    write_sort_mode(1'b0);
    hold_left = 400;
    steady_in = 1'b1;
    send_reads(15);
    steady_in = 1'b0;
  endtask

  // Packets of random readings, end of packet and reads, with some noise
  task automatic test_random_packets();
    int n;
    int t;
    while (item_cnt < 1000) begin
      if ($urandom_range(0, 3) == 0) write_sort_mode($urandom_range(0, 1));
      steady_in = ($urandom_range(0, 3) == 0);
      n = $urandom_range(3, 25);
      repeat (n) begin
        case ($urandom_range(0, 19))
          0: send_item(OP_NONE, ID_W'($urandom), TEMP_W'($urandom));
          1: send_reading($urandom_range(100, 127), $urandom_range(0, 2047));
          2: send_reads(1);             // read while averages are stale
          3, 4: send_reading($urandom_range(0, 99), $urandom_range(0, 2047));
          default: begin
            t = $urandom_range(0, 1400);
            send_reading($urandom_range(0, 99), t - 700);
          end
        endcase
      end
      send_item(OP_EOP, ID_W'($urandom), TEMP_W'($urandom));
      if ($urandom_range(0, 4) == 0) send_reads(eligible_count() + 2);
      else send_reads($urandom_range(1, 20));
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_sort_mode_i = 1'b0;
    in_valid_i = 1'b0;
    opcode_i = OP_ADD;
    sensor_id_i = '0;
    temperature_tenths_i = '0;
    error_cnt = 0;
    item_cnt = 0;
    steady_in = 1'b0;
    burst_left = 0;
    hold_left = 0;
    for (int i = 0; i < NUM_SENSORS; i++) begin
      sum_m[i] = 0;
      count_m[i] = 0;
      avg_m[i] = 0;
    end
    cursor_key = 0;
    cursor_started = 1'b0;
    averages_ready = 1'b0;
    sort_mode_m = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_backpressure();
    write_sort_mode(1'b1);
    write_sort_mode(1'b0);
    test_random_packets();

    // Drain and settle
    @(negedge clk_i);
    in_valid_i = 1'b0;
    wait (entry_q.size() == 0);
    repeat (200) @(posedge clk_i);
    if (error_cnt == 0 && entry_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
